// ===== rtl/core/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types, command codes and constants of the SWD command engine.
// ----------------------------------------------------------------------------
package swd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_SAMPLE  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		JOB_WRITE  = 3'd0,
		JOB_READ   = 3'd1,
		JOB_REPLY  = 3'd2,
		JOB_MATCH  = 3'd3,
		JOB_UNCONF = 3'd4
	} job_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_REPLY = 2'd2,
		KIND_PINS  = 2'd3
	} kind_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_RUN  = 1'b1
	} ctrl_state_t;

	// Host command codes.
	localparam logic [7:0] CMD_READ_WORD      = 8'h10;
	localparam logic [7:0] CMD_READ_BITS_LO   = 8'h20;
	localparam logic [7:0] CMD_READ_BITS_HI   = 8'h27;
	localparam logic [7:0] CMD_SILENT_LO      = 8'h28;
	localparam logic [7:0] CMD_SILENT_HI      = 8'h2f;
	localparam logic [7:0] CMD_WRITE_WORD     = 8'h90;
	localparam logic [7:0] CMD_WRITE_BITS_LO  = 8'ha0;
	localparam logic [7:0] CMD_WRITE_BITS_HI  = 8'ha7;

	// Handshake string "?SWD" followed by "?".
	localparam logic [31:0] MAGIC_HEAD = 32'h3F535744;
	localparam logic [7:0]  MAGIC_TAIL = 8'h3F;

	localparam int JOB_CNT_W = 6;

	localparam logic [2:0]           WORD_BYTES       = 3'd4;
	localparam logic [3:0]           BYTE_BITS        = 4'd8;
	localparam logic [2:0]           WINDOW_FULL      = 3'd4;
	localparam logic [JOB_CNT_W-1:0] READ_WORD_CLOCKS = 6'd32;
	localparam logic [JOB_CNT_W-1:0] MATCH_RESULTS    = 6'd6;

	// Reply "!SWD1", one byte per index.
	function automatic logic [7:0] version_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0:    v = 8'h21;
			3'd1:    v = 8'h53;
			3'd2:    v = 8'h57;
			3'd3:    v = 8'h44;
			3'd4:    v = 8'h31;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	typedef struct packed {
		logic ready;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic accepted;
		logic has_results;
		logic last_result;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/core/swd_in_if.sv =====
// ----------------------------------------------------------------------------
// swd_in_if
// Input channel: host bytes and sampled data line bits.
// ----------------------------------------------------------------------------
interface swd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] host_byte;
	logic       dio_sample;

	modport source (output valid, output cmd, output host_byte, output dio_sample,
		input ready);
	modport sink (input valid, input cmd, input host_byte, input dio_sample,
		output ready);
endinterface

// ===== rtl/core/swd_out_if.sv =====
// ----------------------------------------------------------------------------
// swd_out_if
// Result channel: wire clocks, reply bytes and pin mode changes.
// ----------------------------------------------------------------------------
interface swd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       dio_out;
	logic [7:0] reply_byte;
	logic       pins_enabled;
	logic       last;

	modport source (output valid, output kind, output dio_out, output reply_byte,
		output pins_enabled, output last, input ready);
	modport sink (input valid, input kind, input dio_out, input reply_byte,
		input pins_enabled, input last, output ready);
endinterface

// ===== rtl/core/swd_ctrl.sv =====
// ----------------------------------------------------------------------------
// swd_ctrl
// Controller: accepts one transaction, then steps the datapath through its
// results one per free output slot.
// ----------------------------------------------------------------------------
module swd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  swd_pkg::dp_status_t sts,
	output swd_pkg::ctrl_cmd_t  ctl
);

	swd_pkg::ctrl_state_t state_q;
	swd_pkg::ctrl_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swd_pkg::CS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			swd_pkg::CS_IDLE: begin
				if (sts.accepted && sts.has_results) begin
					state_n = swd_pkg::CS_RUN;
				end
			end
			swd_pkg::CS_RUN: begin
				if (sts.out_free && sts.last_result) begin
					state_n = swd_pkg::CS_IDLE;
				end
			end
			default: state_n = swd_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			swd_pkg::CS_IDLE: ctl.ready = 1'b1;
			swd_pkg::CS_RUN:  ctl.emit  = sts.out_free;
			default:          ctl = '0;
		endcase
	end

endmodule

// ===== rtl/core/swd_datapath.sv =====
// ----------------------------------------------------------------------------
// swd_datapath
// Engine state, command decode, result sequencer and output register.
// ----------------------------------------------------------------------------
module swd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	swd_in_if.sink              host,
	swd_out_if.source           result,
	input  swd_pkg::ctrl_cmd_t  ctl,
	output swd_pkg::dp_status_t sts
);

	// Engine state.
	logic            cfg_q,    cfg_n;
	swd_pkg::phase_t phase_q,  phase_n;
	logic [2:0]      pbl_q,    pbl_n;
	logic [3:0]      pbc_q,    pbc_n;
	logic [31:0]     window_q, window_n;
	logic [2:0]      fill_q,   fill_n;
	logic [3:0]      sbl_q,    sbl_n;
	logic [2:0]      sbytes_q, sbytes_n;
	logic [7:0]      accum_q,  accum_n;
	logic            supp_q,   supp_n;

	// Result job of the current transaction.
	swd_pkg::job_t                 job_mode_q, plan_mode;
	logic [swd_pkg::JOB_CNT_W-1:0] job_cnt_q,  plan_cnt;
	logic [7:0]                    job_data_q, plan_data;

	// Output register.
	logic       res_valid_q;
	logic [1:0] res_kind_q;
	logic       res_dio_q;
	logic [7:0] res_byte_q;
	logic       res_pins_q;
	logic       res_last_q;

	logic       accepted;
	logic       do_clear;
	logic [2:0] bit_idx;
	logic [7:0] acc_new;
	logic [3:0] sbl_dec;
	logic [2:0] sbytes_dec;
	logic [2:0] pbl_dec;
	logic [3:0] cmd_bits;
	logic       magic_hit;

	logic [1:0] emit_kind;
	logic       emit_dio;
	logic [7:0] emit_byte;

	assign host.ready = ctl.ready;
	assign accepted   = host.valid && ctl.ready;

	assign sts.accepted    = accepted;
	assign sts.has_results = (plan_cnt != '0);
	assign sts.last_result = (job_cnt_q == swd_pkg::JOB_CNT_W'(1));
	assign sts.out_free    = !res_valid_q || result.ready;

	assign bit_idx    = 3'(pbc_q - sbl_q);
	assign acc_new    = accum_q | (8'(host.dio_sample) << bit_idx);
	assign sbl_dec    = sbl_q - 4'd1;
	assign sbytes_dec = (sbytes_q != 3'd0) ? sbytes_q - 3'd1 : 3'd0;
	assign pbl_dec    = (pbl_q != 3'd0) ? pbl_q - 3'd1 : 3'd0;
	assign cmd_bits   = {1'b0, host.host_byte[2:0]} + 4'd1;
	assign magic_hit  = (fill_q >= swd_pkg::WINDOW_FULL) && (window_q == swd_pkg::MAGIC_HEAD)
		&& (host.host_byte == swd_pkg::MAGIC_TAIL);

	// Next engine state and result plan for the offered transaction.
	always_comb begin
		cfg_n     = cfg_q;
		phase_n   = phase_q;
		pbl_n     = pbl_q;
		pbc_n     = pbc_q;
		window_n  = window_q;
		fill_n    = fill_q;
		sbl_n     = sbl_q;
		sbytes_n  = sbytes_q;
		accum_n   = accum_q;
		supp_n    = supp_q;
		do_clear  = 1'b0;
		plan_mode = swd_pkg::JOB_READ;
		plan_cnt  = '0;
		plan_data = '0;

		if (host.cmd) begin
			if (cfg_q && phase_q == swd_pkg::PH_SAMPLE && sbl_q != 4'd0) begin
				if (sbl_dec == 4'd0) begin
					if (!supp_q) begin
						plan_mode = swd_pkg::JOB_REPLY;
						plan_cnt  = swd_pkg::JOB_CNT_W'(1);
						plan_data = acc_new;
					end
					accum_n = 8'd0;
					if (sbytes_dec == 3'd0) begin
						do_clear = 1'b1;
					end else begin
						sbytes_n = sbytes_dec;
						sbl_n    = pbc_q;
					end
				end else begin
					sbl_n   = sbl_dec;
					accum_n = acc_new;
				end
			end
		end else if (!cfg_q) begin
			if (magic_hit) begin
				window_n  = 32'd0;
				fill_n    = 3'd0;
				cfg_n     = 1'b1;
				plan_mode = swd_pkg::JOB_MATCH;
				plan_cnt  = swd_pkg::MATCH_RESULTS;
			end else begin
				window_n = {window_q[23:0], host.host_byte};
				if (fill_q < swd_pkg::WINDOW_FULL) begin
					fill_n = fill_q + 3'd1;
				end
			end
		end else if (phase_q == swd_pkg::PH_SAMPLE) begin
			// Host bytes are dropped while samples are outstanding.
		end else if (phase_q == swd_pkg::PH_PAYLOAD) begin
			plan_mode = swd_pkg::JOB_WRITE;
			plan_cnt  = (pbc_q > swd_pkg::BYTE_BITS) ? swd_pkg::JOB_CNT_W'(swd_pkg::BYTE_BITS)
				: swd_pkg::JOB_CNT_W'(pbc_q);
			plan_data = host.host_byte;
			pbl_n     = pbl_dec;
			if (pbl_dec == 3'd0) begin
				do_clear = 1'b1;
			end
		end else begin
			unique case (host.host_byte) inside
				swd_pkg::CMD_READ_WORD: begin
					plan_mode = swd_pkg::JOB_READ;
					plan_cnt  = swd_pkg::READ_WORD_CLOCKS;
					phase_n   = swd_pkg::PH_SAMPLE;
					pbc_n     = swd_pkg::BYTE_BITS;
					sbl_n     = swd_pkg::BYTE_BITS;
					sbytes_n  = swd_pkg::WORD_BYTES;
					accum_n   = 8'd0;
					supp_n    = 1'b0;
				end
				[swd_pkg::CMD_READ_BITS_LO:swd_pkg::CMD_READ_BITS_HI],
				[swd_pkg::CMD_SILENT_LO:swd_pkg::CMD_SILENT_HI]: begin
					plan_mode = swd_pkg::JOB_READ;
					plan_cnt  = swd_pkg::JOB_CNT_W'(cmd_bits);
					phase_n   = swd_pkg::PH_SAMPLE;
					pbc_n     = cmd_bits;
					sbl_n     = cmd_bits;
					sbytes_n  = 3'd1;
					accum_n   = 8'd0;
					// Silent clocks share the read path but drop the reply.
					supp_n    = host.host_byte[3];
				end
				swd_pkg::CMD_WRITE_WORD: begin
					phase_n = swd_pkg::PH_PAYLOAD;
					pbl_n   = swd_pkg::WORD_BYTES;
					pbc_n   = swd_pkg::BYTE_BITS;
				end
				[swd_pkg::CMD_WRITE_BITS_LO:swd_pkg::CMD_WRITE_BITS_HI]: begin
					phase_n = swd_pkg::PH_PAYLOAD;
					pbl_n   = 3'd1;
					pbc_n   = cmd_bits;
				end
				default: begin
					// The unknown byte restarts the search as its first window byte.
					cfg_n     = 1'b0;
					do_clear  = 1'b1;
					window_n  = {24'd0, host.host_byte};
					fill_n    = 3'd1;
					plan_mode = swd_pkg::JOB_UNCONF;
					plan_cnt  = swd_pkg::JOB_CNT_W'(1);
				end
			endcase
		end

		if (do_clear) begin
			phase_n  = swd_pkg::PH_IDLE;
			pbl_n    = 3'd0;
			pbc_n    = 4'd0;
			sbl_n    = 4'd0;
			sbytes_n = 3'd0;
			accum_n  = 8'd0;
			supp_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= 1'b0;
			phase_q  <= swd_pkg::PH_IDLE;
			pbl_q    <= 3'd0;
			pbc_q    <= 4'd0;
			window_q <= 32'd0;
			fill_q   <= 3'd0;
			sbl_q    <= 4'd0;
			sbytes_q <= 3'd0;
			accum_q  <= 8'd0;
			supp_q   <= 1'b0;
		end else if (accepted) begin
			cfg_q    <= cfg_n;
			phase_q  <= phase_n;
			pbl_q    <= pbl_n;
			pbc_q    <= pbc_n;
			window_q <= window_n;
			fill_q   <= fill_n;
			sbl_q    <= sbl_n;
			sbytes_q <= sbytes_n;
			accum_q  <= accum_n;
			supp_q   <= supp_n;
		end
	end

	// One result of the current job.
	always_comb begin
		emit_kind = swd_pkg::KIND_READ;
		emit_dio  = 1'b0;
		emit_byte = 8'd0;
		case (job_mode_q)
			swd_pkg::JOB_WRITE: begin
				emit_kind = swd_pkg::KIND_WRITE;
				emit_dio  = job_data_q[0];
			end
			swd_pkg::JOB_READ: emit_kind = swd_pkg::KIND_READ;
			swd_pkg::JOB_REPLY: begin
				emit_kind = swd_pkg::KIND_REPLY;
				emit_byte = job_data_q;
			end
			swd_pkg::JOB_MATCH: begin
				// The pin change leads, then the five version bytes.
				if (job_cnt_q == swd_pkg::MATCH_RESULTS) begin
					emit_kind = swd_pkg::KIND_PINS;
				end else begin
					emit_kind = swd_pkg::KIND_REPLY;
					emit_byte = swd_pkg::version_byte(
						3'(swd_pkg::MATCH_RESULTS - swd_pkg::JOB_CNT_W'(1) - job_cnt_q));
				end
			end
			swd_pkg::JOB_UNCONF: emit_kind = swd_pkg::KIND_PINS;
			default: emit_kind = swd_pkg::KIND_READ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_mode_q <= swd_pkg::JOB_READ;
			job_cnt_q  <= '0;
			job_data_q <= 8'd0;
		end else if (accepted) begin
			job_mode_q <= plan_mode;
			job_cnt_q  <= plan_cnt;
			job_data_q <= plan_data;
		end else if (ctl.emit) begin
			job_cnt_q <= job_cnt_q - swd_pkg::JOB_CNT_W'(1);
			if (job_mode_q == swd_pkg::JOB_WRITE) begin
				job_data_q <= {1'b0, job_data_q[7:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_kind_q <= emit_kind;
			res_dio_q  <= emit_dio;
			res_byte_q <= emit_byte;
			res_pins_q <= cfg_q;
			res_last_q <= (job_cnt_q == swd_pkg::JOB_CNT_W'(1));
		end
	end

	assign result.valid        = res_valid_q;
	assign result.kind         = res_kind_q;
	assign result.dio_out      = res_dio_q;
	assign result.reply_byte   = res_byte_q;
	assign result.pins_enabled = res_pins_q;
	assign result.last         = res_last_q;

endmodule

// ===== rtl/core/swd_command_engine_top.sv =====
// ----------------------------------------------------------------------------
// swd_command_engine_top
// Turns host command bytes into SWD write and read clocks and reply bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake     Payload
//  host      in         valid/ready   cmd, host_byte, dio_sample
//  result    out        valid/ready   kind, dio_out, reply_byte, pins_enabled, last
//
// A transaction is accepted while the controller is idle; its N results then
// leave one per cycle through the output register while it is not stalled
// (N up to 32 for a read word, 8 for a write payload byte).
// The result sequencer's count sets N; the next transaction waits
// until the last result has entered the output register.
// Reset clears the engine unconfigured with the handshake search window empty.
// A stalled result holds in the output register and the sequencer waits.
//
module swd_command_engine_top (
	input logic clk,
	input logic arst_n,
	swd_in_if.sink    host,
	swd_out_if.source result
);

	swd_pkg::ctrl_cmd_t  ctl;
	swd_pkg::dp_status_t sts;

	swd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	swd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.host   (host),
		.result (result),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule

// ===== tb/swd_command_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_command_engine_top_tb
// Self-checking bench for the SWD command engine. A directed table walks the
// handshake string, every command but the word read, dropped bytes, stray
// samples and the unconfigure path. A random part follows, made mostly of
// well-formed command sequences. Every result is compared against a predictor
// kept in step with the accepted host transactions.
// ----------------------------------------------------------------------------
module swd_command_engine_top_tb;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 370;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int NO_CHECK     = -1;

	typedef struct packed {
		swd_pkg::kind_t kind;
		logic           dio;
		logic [7:0]     rbyte;
		logic           pins;
		logic           last;
	} wire_op_t;

	typedef struct packed {
		logic           c;
		logic [7:0]     hb;
		logic           ds;
		int             exp_n;
		swd_pkg::kind_t exp_kind;
		logic           exp_pins;
	} stim_row_t;

	localparam int SCRIPT_LEN = 27;

	// Expected op count, kind and pin state of the first op are typed in only
	// where they are obvious; other rows rely on the predictor alone.
	stim_row_t script [SCRIPT_LEN] = '{
		'{1'b1, 8'h00, 1'b1, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, 8'h00, 1'b0, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[31:24], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[23:16], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[15:8], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[7:0], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_TAIL, 1'b0, 6, swd_pkg::KIND_PINS, 1'b1},
		'{1'b0, swd_pkg::CMD_READ_BITS_LO, 1'b0, 1, swd_pkg::KIND_READ, 1'b1},
		'{1'b0, 8'hff, 1'b1, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b1, 8'hff, 1'b1, 1, swd_pkg::KIND_REPLY, 1'b1},
		'{1'b0, swd_pkg::CMD_SILENT_LO, 1'b0, 1, swd_pkg::KIND_READ, 1'b1},
		'{1'b1, 8'h00, 1'b1, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::CMD_WRITE_WORD, 1'b0, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, 8'h00, 1'b1, 8, swd_pkg::KIND_WRITE, 1'b1},
		'{1'b0, 8'hff, 1'b0, 8, swd_pkg::KIND_WRITE, 1'b1},
		'{1'b0, 8'ha5, 1'b1, 8, swd_pkg::KIND_WRITE, 1'b1},
		'{1'b0, 8'h5a, 1'b0, 8, swd_pkg::KIND_WRITE, 1'b1},
		'{1'b0, swd_pkg::CMD_WRITE_BITS_HI, 1'b0, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, 8'h80, 1'b0, 8, swd_pkg::KIND_WRITE, 1'b1},
		'{1'b0, swd_pkg::CMD_WRITE_BITS_LO, 1'b0, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, 8'hff, 1'b0, 1, swd_pkg::KIND_WRITE, 1'b1},
		'{1'b1, 8'h00, 1'b1, 0, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_TAIL, 1'b0, 1, swd_pkg::KIND_PINS, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[23:16], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[15:8], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_HEAD[7:0], 1'b0, NO_CHECK, swd_pkg::KIND_WRITE, 1'b0},
		'{1'b0, swd_pkg::MAGIC_TAIL, 1'b0, 6, swd_pkg::KIND_PINS, 1'b1}
	};

	logic clk;
	logic arst_n;

	swd_in_if  host_ch ();
	swd_out_if res_ch ();

	swd_command_engine_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.host   (host_ch),
		.result (res_ch)
	);

	// Predictor state.
	logic            cfg_on;
	swd_pkg::phase_t ph;
	logic [2:0]      pay_left;
	logic [3:0]      bit_cnt;
	logic [31:0]     win;
	logic [2:0]      fill;
	logic [3:0]      smp_left;
	logic [2:0]      smp_bytes;
	logic [7:0]      accum;
	logic            quiet;

	logic [7:0] version_reply [5] = '{8'h21, 8'h53, 8'h57, 8'h44, 8'h31};

	wire_op_t expected_wire_ops [$];
	wire_op_t pend;
	wire_op_t first_op;
	bit       have_pend;
	int       op_count;
	bit       item_ignored;

	int  errors;
	int  cycle_cnt;
	bit  calm;
	bit  hold_req;
	bit  hold_done;
	int  stall_cnt;

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch #%0d: %s", $realtime, errors, what);
	endtask

	task automatic queue_op(input swd_pkg::kind_t k, input logic d, input logic [7:0] rb);
		if (have_pend)
			expected_wire_ops.push_back(pend);
		pend = '{kind: k, dio: d, rbyte: rb, pins: cfg_on, last: 1'b0};
		have_pend = 1'b1;
		if (op_count == 0)
			first_op = pend;
		op_count++;
	endtask

	task automatic clear_progress();
		ph        = swd_pkg::PH_IDLE;
		pay_left  = '0;
		bit_cnt   = '0;
		smp_left  = '0;
		smp_bytes = '0;
		accum     = '0;
		quiet     = 1'b0;
	endtask

	task automatic hunt_handshake(input logic [7:0] b);
		if (fill >= swd_pkg::WINDOW_FULL && win == swd_pkg::MAGIC_HEAD &&
			b == swd_pkg::MAGIC_TAIL) begin
			win    = '0;
			fill   = '0;
			cfg_on = 1'b1;
			queue_op(swd_pkg::KIND_PINS, 1'b0, 8'h00);
			for (int i = 0; i < 5; i++)
				queue_op(swd_pkg::KIND_REPLY, 1'b0, version_reply[i]);
		end else begin
			win = {win[23:0], b};
			if (fill < swd_pkg::WINDOW_FULL)
				fill++;
		end
	endtask

	task automatic start_clocks(input logic [3:0] bits, input logic [2:0] bytes,
		input logic silent);
		for (int i = 0; i < int'(bits) * int'(bytes); i++)
			queue_op(swd_pkg::KIND_READ, 1'b0, 8'h00);
		ph        = swd_pkg::PH_SAMPLE;
		bit_cnt   = bits;
		smp_left  = bits;
		smp_bytes = bytes;
		accum     = '0;
		quiet     = silent;
	endtask

	// Works out the wire ops caused by one accepted host transaction.
	task automatic predict_wire_activity(input logic c, input logic [7:0] hb,
		input logic ds);
		logic [3:0] idx;
		int         nb;
		op_count     = 0;
		have_pend    = 1'b0;
		item_ignored = 1'b0;
		if (c) begin
			if (cfg_on && ph == swd_pkg::PH_SAMPLE && smp_left != 0) begin
				idx   = (bit_cnt - smp_left) & 4'd7;
				accum = accum | (8'(ds) << idx[2:0]);
				smp_left--;
				if (smp_left == 0) begin
					if (!quiet)
						queue_op(swd_pkg::KIND_REPLY, 1'b0, accum);
					accum = '0;
					if (smp_bytes > 0)
						smp_bytes--;
					if (smp_bytes == 0)
						clear_progress();
					else
						smp_left = bit_cnt;
				end
			end else begin
				item_ignored = 1'b1;
			end
		end else if (!cfg_on) begin
			hunt_handshake(hb);
		end else if (ph == swd_pkg::PH_SAMPLE) begin
			item_ignored = 1'b1;
		end else if (ph == swd_pkg::PH_PAYLOAD) begin
			nb = (bit_cnt > swd_pkg::BYTE_BITS) ? int'(swd_pkg::BYTE_BITS) : int'(bit_cnt);
			for (int i = 0; i < nb; i++)
				queue_op(swd_pkg::KIND_WRITE, hb[i], 8'h00);
			if (pay_left > 0)
				pay_left--;
			if (pay_left == 0)
				clear_progress();
		end else if (hb == swd_pkg::CMD_READ_WORD) begin
			start_clocks(swd_pkg::BYTE_BITS, swd_pkg::WORD_BYTES, 1'b0);
		end else if (hb[7:3] == swd_pkg::CMD_READ_BITS_LO[7:3]) begin
			start_clocks({1'b0, hb[2:0]} + 4'd1, 3'd1, 1'b0);
		end else if (hb[7:3] == swd_pkg::CMD_SILENT_LO[7:3]) begin
			start_clocks({1'b0, hb[2:0]} + 4'd1, 3'd1, 1'b1);
		end else if (hb == swd_pkg::CMD_WRITE_WORD) begin
			ph       = swd_pkg::PH_PAYLOAD;
			pay_left = swd_pkg::WORD_BYTES;
			bit_cnt  = swd_pkg::BYTE_BITS;
		end else if (hb[7:3] == swd_pkg::CMD_WRITE_BITS_LO[7:3]) begin
			ph       = swd_pkg::PH_PAYLOAD;
			pay_left = 3'd1;
			bit_cnt  = {1'b0, hb[2:0]} + 4'd1;
		end else begin
			// Unknown byte: drop the pins and start a new search with this byte.
			cfg_on = 1'b0;
			clear_progress();
			win  = '0;
			fill = '0;
			queue_op(swd_pkg::KIND_PINS, 1'b0, 8'h00);
			hunt_handshake(hb);
		end
		if (have_pend) begin
			pend.last = 1'b1;
			expected_wire_ops.push_back(pend);
		end
	endtask

	task automatic send_item(input logic c, input logic [7:0] hb, input logic ds);
		while (!calm && $urandom_range(0, 99) < 29) begin
			host_ch.valid <= 1'b0;
			@(posedge clk);
		end
		host_ch.valid      <= 1'b1;
		host_ch.cmd        <= c;
		host_ch.host_byte  <= hb;
		host_ch.dio_sample <= ds;
		@(posedge clk);
		while (!host_ch.ready)
			@(posedge clk);
		predict_wire_activity(c, hb, ds);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(1'b0, b, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_sample(input logic s);
		send_item(1'b1, 8'($urandom_range(0, 255)), s);
	endtask

	task automatic check_wire_op();
		wire_op_t exp;
		if (expected_wire_ops.size() == 0) begin
			report_mismatch($sformatf("unexpected op kind=%0d dio=%0b byte=%02h",
				res_ch.kind, res_ch.dio_out, res_ch.reply_byte));
		end else begin
			exp = expected_wire_ops.pop_front();
			if (res_ch.kind !== exp.kind || res_ch.dio_out !== exp.dio ||
				res_ch.reply_byte !== exp.rbyte || res_ch.pins_enabled !== exp.pins ||
				res_ch.last !== exp.last)
				report_mismatch($sformatf(
					"got k=%0d d=%0b b=%02h p=%0b l=%0b, want k=%0d d=%0b b=%02h p=%0b l=%0b",
					res_ch.kind, res_ch.dio_out, res_ch.reply_byte, res_ch.pins_enabled,
					res_ch.last, exp.kind, exp.dio, exp.rbyte, exp.pins, exp.last));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL swd_command_engine_top");
		$finish;
	end

	// Result side: checks each accepted result and drives ready.
	initial begin
		res_ch.ready <= 1'b0;
		stall_cnt = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_wire_op();
			if (stall_cnt > 0) begin
				stall_cnt--;
				res_ch.ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				// Long hold-off so the engine fills up and back-pressures the host.
				hold_done = 1'b1;
				stall_cnt = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (calm) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= 29);
			end
		end
	end

	initial begin
		int useful;
		int pick;
		arst_n             <= 1'b0;
		host_ch.valid      <= 1'b0;
		host_ch.cmd        <= 1'b0;
		host_ch.host_byte  <= 8'h00;
		host_ch.dio_sample <= 1'b0;
		errors   = 0;
		calm     = 1'b0;
		hold_req = 1'b0;
		cfg_on   = 1'b0;
		win      = '0;
		fill     = '0;
		clear_progress();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			send_item(script[r].c, script[r].hb, script[r].ds);
			if (script[r].exp_n != NO_CHECK) begin
				if (op_count != script[r].exp_n)
					report_mismatch($sformatf("row %0d: predicted %0d ops, table says %0d",
						r, op_count, script[r].exp_n));
				else if (op_count > 0 && (first_op.kind != script[r].exp_kind ||
					first_op.pins != script[r].exp_pins))
					report_mismatch($sformatf("row %0d: first op differs from table", r));
			end
		end

		useful = 0;
		while (useful < RANDOM_ITEMS) begin
			calm     = (useful >= 120 && useful < 200);
			hold_req = (useful >= 260);
			pick     = $urandom_range(0, 99);
			if (!cfg_on) begin
				if (pick < 85) begin
					for (int k = 0; k < 5; k++) begin
						if (!cfg_on) begin
							send_byte((k == 4) ? swd_pkg::MAGIC_TAIL
								: swd_pkg::MAGIC_HEAD[31 - 8*k -: 8]);
							useful += item_ignored ? 0 : 1;
						end
					end
				end else if (pick < 95) begin
					send_byte(8'($urandom_range(0, 255)));
				end else begin
					send_sample(1'($urandom_range(0, 1)));
				end
			end else if (ph == swd_pkg::PH_SAMPLE) begin
				if (pick < 8)
					send_byte(8'($urandom_range(0, 255)));
				else
					send_sample(1'($urandom_range(0, 1)));
			end else if (ph == swd_pkg::PH_PAYLOAD) begin
				if (pick < 10)
					send_byte(8'h00);
				else if (pick < 20)
					send_byte(8'hff);
				else
					send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 12) begin
				send_byte(swd_pkg::CMD_READ_WORD);
			end else if (pick < 30) begin
				send_byte(swd_pkg::CMD_READ_BITS_LO | 8'($urandom_range(0, 7)));
			end else if (pick < 44) begin
				send_byte(swd_pkg::CMD_SILENT_LO | 8'($urandom_range(0, 7)));
			end else if (pick < 58) begin
				send_byte(swd_pkg::CMD_WRITE_WORD);
			end else if (pick < 76) begin
				send_byte(swd_pkg::CMD_WRITE_BITS_LO | 8'($urandom_range(0, 7)));
			end else if (pick < 92) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_sample(1'($urandom_range(0, 1)));
			end
			if (!(pick < 85 && !cfg_on && op_count == 0 && ph == swd_pkg::PH_IDLE))
				useful += item_ignored ? 0 : 1;
		end
		host_ch.valid <= 1'b0;
		calm = 1'b0;

		while (expected_wire_ops.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS swd_command_engine_top");
		else
			$display("FAIL swd_command_engine_top");
		$finish;
	end

endmodule
